### rtl/sct_pkg.sv
package sct_pkg;

    localparam int OFFSET_BITS_DEFAULT = 24;
    localparam int LENGTH_BITS_DEFAULT = 12;
    localparam int LINE_BITS_DEFAULT   = 16;

    typedef enum logic [4:0] {
        KIND_EOF      = 5'd0,
        KIND_NEWLINE  = 5'd1,
        KIND_LPAREN   = 5'd2,
        KIND_RPAREN   = 5'd3,
        KIND_EQ       = 5'd4,
        KIND_EQ_EQ    = 5'd5,
        KIND_PLUS     = 5'd6,
        KIND_PLUS_EQ  = 5'd7,
        KIND_MINUS    = 5'd8,
        KIND_STAR     = 5'd9,
        KIND_SLASH    = 5'd10,
        KIND_PERCENT  = 5'd11,
        KIND_COMMA    = 5'd12,
        KIND_SYMBOL   = 5'd13,
        KIND_PROC     = 5'd14,
        KIND_LET      = 5'd15,
        KIND_MUT      = 5'd16,
        KIND_INTEGER  = 5'd17,
        KIND_FLOAT    = 5'd18,
        KIND_ILLEGAL  = 5'd19
    } kind_t;

    // queue write request from the scanner
    typedef struct packed {
        logic [1:0] count;
    } sct_wr_t;

endpackage

### rtl/sct_if.sv
interface sct_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_source;

    modport source (output valid, output char_code, output end_of_source, input ready);
    modport sink (input valid, input char_code, input end_of_source, output ready);
endinterface

interface sct_tok_if #(
    parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEFAULT,
    parameter int LENGTH_BITS = sct_pkg::LENGTH_BITS_DEFAULT,
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    sct_pkg::kind_t         kind;
    logic [OFFSET_BITS-1:0] byte_position;
    logic [LENGTH_BITS-1:0] token_length;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   column;
    logic                   last_of_run;

    modport source (
        output valid, output kind, output byte_position, output token_length,
        output line, output column, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input byte_position, input token_length,
        input line, input column, input last_of_run, output ready
    );
endinterface

### rtl/sct_scan.sv
module sct_scan #(
    parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEFAULT,
    parameter int LENGTH_BITS = sct_pkg::LENGTH_BITS_DEFAULT,
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  logic [7:0]             char_code,
    input  logic                   end_of_source,
    input  logic                   room,
    output sct_pkg::sct_wr_t       wr,
    output sct_pkg::kind_t         res_kind     [2],
    output logic [OFFSET_BITS-1:0] res_position [2],
    output logic [LENGTH_BITS-1:0] res_length   [2],
    output logic [LINE_BITS-1:0]   res_line     [2],
    output logic [LINE_BITS-1:0]   res_column   [2],
    output logic                   res_last     [2]
);
    import sct_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_EQ,
        MODE_PLUS,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_INT,
        MODE_FLOAT
    } mode_t;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_A_LOW   = 8'h61;
    localparam logic [7:0] CH_C_LOW   = 8'h63;
    localparam logic [7:0] CH_E_LOW   = 8'h65;
    localparam logic [7:0] CH_L_LOW   = 8'h6c;
    localparam logic [7:0] CH_M_LOW   = 8'h6d;
    localparam logic [7:0] CH_O_LOW   = 8'h6f;
    localparam logic [7:0] CH_P_LOW   = 8'h70;
    localparam logic [7:0] CH_R_LOW   = 8'h72;
    localparam logic [7:0] CH_T_LOW   = 8'h74;
    localparam logic [7:0] CH_U_LOW   = 8'h75;
    localparam logic [7:0] CH_Z_LOW   = 8'h7a;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [3:0] KW_NONE = 4'd0;
    localparam logic [3:0] KW_P    = 4'd1;
    localparam logic [3:0] KW_PR   = 4'd2;
    localparam logic [3:0] KW_PRO  = 4'd3;
    localparam logic [3:0] KW_PROC = 4'd4;
    localparam logic [3:0] KW_L    = 4'd5;
    localparam logic [3:0] KW_LE   = 4'd6;
    localparam logic [3:0] KW_LET  = 4'd7;
    localparam logic [3:0] KW_M    = 4'd8;
    localparam logic [3:0] KW_MU   = 4'd9;
    localparam logic [3:0] KW_MUT  = 4'd10;

    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);
    localparam logic [LENGTH_BITS-1:0] LEN_TOP = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   CNT_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]   CNT_TOP = {LINE_BITS{1'b1}};

    function automatic logic [3:0] kw_start(input logic [7:0] c);
        logic [3:0] t;
        case (c)
            CH_P_LOW: t = KW_P;
            CH_L_LOW: t = KW_L;
            CH_M_LOW: t = KW_M;
            default:  t = KW_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_follow(input logic [3:0] t, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        case (t)
            KW_P:    if (c == CH_R_LOW) r = KW_PR;
            KW_PR:   if (c == CH_O_LOW) r = KW_PRO;
            KW_PRO:  if (c == CH_C_LOW) r = KW_PROC;
            KW_L:    if (c == CH_E_LOW) r = KW_LE;
            KW_LE:   if (c == CH_T_LOW) r = KW_LET;
            KW_M:    if (c == CH_U_LOW) r = KW_MU;
            KW_MU:   if (c == CH_T_LOW) r = KW_MUT;
            default: r = KW_NONE;
        endcase
        return r;
    endfunction

    // input register
    logic       stage_valid_reg;
    logic [7:0] char_reg;
    logic       eos_reg;
    logic       consume;

    // scanner state
    mode_t                  mode_reg, mode_next;
    logic [3:0]             kw_reg, kw_next;
    logic [OFFSET_BITS-1:0] pend_off_reg, pend_off_next;
    logic [LINE_BITS-1:0]   pend_col_reg, pend_col_next;
    logic [LENGTH_BITS-1:0] pend_len_reg, pend_len_next;
    logic [OFFSET_BITS-1:0] byte_cnt_reg, byte_cnt_next;
    logic [LINE_BITS-1:0]   line_cnt_reg, line_cnt_next;
    logic [LINE_BITS-1:0]   col_cnt_reg, col_cnt_next;

    // flushed token and main token of this transfer
    logic                   f_valid, m_valid;
    kind_t                  f_kind, m_kind;
    logic [OFFSET_BITS-1:0] f_off, m_off;
    logic [LENGTH_BITS-1:0] f_len, m_len;
    logic [LINE_BITS-1:0]   f_col, m_col;

    logic                   redo;
    logic                   is_letter, is_digit, is_ident_char;
    logic [7:0]             c_low;
    logic [OFFSET_BITS-1:0] byte_inc;
    logic [LINE_BITS-1:0]   col_inc;
    logic [LENGTH_BITS-1:0] len_inc;

    assign consume    = stage_valid_reg && room;
    assign char_ready = !stage_valid_reg || consume;

    assign c_low         = char_reg | CASE_BIT;
    assign is_letter     = c_low inside {[CH_A_LOW:CH_Z_LOW]};
    assign is_digit      = char_reg inside {[CH_0:CH_9]};
    assign is_ident_char = is_letter || is_digit || (char_reg == CH_UNDER);
    assign byte_inc      = byte_cnt_reg + OFFSET_BITS'(1);
    assign col_inc       = (col_cnt_reg == CNT_TOP) ? col_cnt_reg : col_cnt_reg + CNT_ONE;
    assign len_inc       = (pend_len_reg == LEN_TOP) ? pend_len_reg : pend_len_reg + LEN_ONE;

    // pending token as it stands
    always_comb
    begin
        f_valid = 1'b0;
        f_kind  = KIND_SYMBOL;
        f_off   = pend_off_reg;
        f_len   = pend_len_reg;
        f_col   = pend_col_reg;
        case (mode_reg)
            MODE_EQ:
            begin
                f_valid = 1'b1;
                f_kind  = KIND_EQ;
                f_len   = LEN_ONE;
            end
            MODE_PLUS:
            begin
                f_valid = 1'b1;
                f_kind  = KIND_PLUS;
                f_len   = LEN_ONE;
            end
            MODE_IDENT:
            begin
                f_valid = 1'b1;
                if (kw_reg == KW_PROC)
                    f_kind = KIND_PROC;
                else if (kw_reg == KW_LET)
                    f_kind = KIND_LET;
                else if (kw_reg == KW_MUT)
                    f_kind = KIND_MUT;
                else
                    f_kind = KIND_SYMBOL;
            end
            MODE_INT:
            begin
                f_valid = 1'b1;
                f_kind  = KIND_INTEGER;
            end
            MODE_FLOAT:
            begin
                f_valid = 1'b1;
                f_kind  = KIND_FLOAT;
            end
            default:
            begin
                f_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        kw_next       = kw_reg;
        pend_off_next = pend_off_reg;
        pend_col_next = pend_col_reg;
        pend_len_next = pend_len_reg;
        byte_cnt_next = byte_cnt_reg;
        line_cnt_next = line_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        m_valid       = 1'b0;
        m_kind        = KIND_ILLEGAL;
        m_off         = byte_cnt_reg;
        m_len         = LEN_ONE;
        m_col         = col_cnt_reg;
        redo          = 1'b0;
        wr.count      = 2'd0;

        if (eos_reg)
        begin
            // flush, eof, then back to reset values
            m_valid       = 1'b1;
            m_kind        = KIND_EOF;
            mode_next     = MODE_IDLE;
            kw_next       = KW_NONE;
            pend_off_next = '0;
            pend_col_next = CNT_ONE;
            pend_len_next = '0;
            byte_cnt_next = '0;
            line_cnt_next = CNT_ONE;
            col_cnt_next  = CNT_ONE;
        end
        else
        begin
            case (mode_reg)
                MODE_EQ, MODE_PLUS:
                begin
                    if (char_reg == CH_EQUALS)
                    begin
                        m_valid       = 1'b1;
                        m_kind        = (mode_reg == MODE_EQ) ? KIND_EQ_EQ : KIND_PLUS_EQ;
                        m_off         = pend_off_reg;
                        m_len         = LEN_TWO;
                        m_col         = pend_col_reg;
                        mode_next     = MODE_IDLE;
                        byte_cnt_next = byte_inc;
                        col_cnt_next  = col_inc;
                    end
                    else
                        redo = 1'b1;
                end
                MODE_COMMENT:
                begin
                    if (char_reg == CH_LF)
                        redo = 1'b1;
                    else
                    begin
                        byte_cnt_next = byte_inc;
                        col_cnt_next  = col_inc;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_ident_char)
                    begin
                        kw_next       = kw_follow(kw_reg, char_reg);
                        pend_len_next = len_inc;
                        byte_cnt_next = byte_inc;
                        col_cnt_next  = col_inc;
                    end
                    else
                        redo = 1'b1;
                end
                MODE_INT:
                begin
                    if (is_digit || char_reg == CH_UNDER || char_reg == CH_DOT)
                    begin
                        if (char_reg == CH_DOT)
                            mode_next = MODE_FLOAT;
                        pend_len_next = len_inc;
                        byte_cnt_next = byte_inc;
                        col_cnt_next  = col_inc;
                    end
                    else
                        redo = 1'b1;
                end
                MODE_FLOAT:
                begin
                    if (is_digit || char_reg == CH_UNDER)
                    begin
                        pend_len_next = len_inc;
                        byte_cnt_next = byte_inc;
                        col_cnt_next  = col_inc;
                    end
                    else
                        redo = 1'b1;
                end
                default:
                begin
                    redo = 1'b1;
                end
            endcase

            if (redo)
            begin
                // byte starts afresh from idle
                mode_next     = MODE_IDLE;
                kw_next       = KW_NONE;
                byte_cnt_next = byte_inc;
                col_cnt_next  = col_inc;
                case (char_reg)
                    CH_SPACE, CH_TAB, CH_CR:
                    begin
                        m_valid = 1'b0;
                    end
                    CH_LF:
                    begin
                        m_valid       = 1'b1;
                        m_kind        = KIND_NEWLINE;
                        line_cnt_next = (line_cnt_reg == CNT_TOP) ? line_cnt_reg
                                                                  : line_cnt_reg + CNT_ONE;
                        col_cnt_next  = CNT_ONE;
                    end
                    CH_EQUALS, CH_PLUS:
                    begin
                        mode_next     = (char_reg == CH_EQUALS) ? MODE_EQ : MODE_PLUS;
                        pend_off_next = byte_cnt_reg;
                        pend_col_next = col_cnt_reg;
                        pend_len_next = LEN_ONE;
                    end
                    CH_HASH:
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    CH_LPAREN:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_LPAREN;
                    end
                    CH_RPAREN:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_RPAREN;
                    end
                    CH_MINUS:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_MINUS;
                    end
                    CH_STAR:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_STAR;
                    end
                    CH_SLASH:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_SLASH;
                    end
                    CH_PERCENT:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_PERCENT;
                    end
                    CH_COMMA:
                    begin
                        m_valid = 1'b1;
                        m_kind  = KIND_COMMA;
                    end
                    default:
                    begin
                        if (is_letter || char_reg == CH_UNDER || is_digit)
                        begin
                            mode_next     = is_digit ? MODE_INT : MODE_IDENT;
                            kw_next       = is_digit ? KW_NONE : kw_start(char_reg);
                            pend_off_next = byte_cnt_reg;
                            pend_col_next = col_cnt_reg;
                            pend_len_next = LEN_ONE;
                        end
                        else
                        begin
                            m_valid = 1'b1;
                            m_kind  = KIND_ILLEGAL;
                        end
                    end
                endcase
            end
        end

        // a pending token is flushed on end or when the byte does not extend it
        if (consume)
            wr.count = 2'(((eos_reg || redo) && f_valid) ? 1 : 0) + 2'(m_valid ? 1 : 0);
    end

    // slot 0 takes the flushed token first, slot 1 the main token
    always_comb
    begin
        if ((eos_reg || redo) && f_valid)
        begin
            res_kind[0]     = f_kind;
            res_position[0] = f_off;
            res_length[0]   = f_len;
            res_column[0]   = f_col;
            res_last[0]     = !m_valid;
        end
        else
        begin
            res_kind[0]     = m_kind;
            res_position[0] = m_off;
            res_length[0]   = m_len;
            res_column[0]   = m_col;
            res_last[0]     = 1'b1;
        end
        res_line[0]     = line_cnt_reg;
        res_kind[1]     = m_kind;
        res_position[1] = m_off;
        res_length[1]   = m_len;
        res_column[1]   = m_col;
        res_line[1]     = line_cnt_reg;
        res_last[1]     = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= MODE_IDLE;
            kw_reg          <= KW_NONE;
            pend_off_reg    <= '0;
            pend_col_reg    <= CNT_ONE;
            pend_len_reg    <= '0;
            byte_cnt_reg    <= '0;
            line_cnt_reg    <= CNT_ONE;
            col_cnt_reg     <= CNT_ONE;
        end
        else
        begin
            if (char_ready)
                stage_valid_reg <= char_valid;
            if (consume)
            begin
                mode_reg     <= mode_next;
                kw_reg       <= kw_next;
                pend_off_reg <= pend_off_next;
                pend_col_reg <= pend_col_next;
                pend_len_reg <= pend_len_next;
                byte_cnt_reg <= byte_cnt_next;
                line_cnt_reg <= line_cnt_next;
                col_cnt_reg  <= col_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            char_reg <= char_code;
            eos_reg  <= end_of_source;
        end
    end

endmodule

### rtl/sct_queue.sv
module sct_queue #(
    parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEFAULT,
    parameter int LENGTH_BITS = sct_pkg::LENGTH_BITS_DEFAULT,
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sct_pkg::sct_wr_t       wr,
    input  sct_pkg::kind_t         res_kind     [2],
    input  logic [OFFSET_BITS-1:0] res_position [2],
    input  logic [LENGTH_BITS-1:0] res_length   [2],
    input  logic [LINE_BITS-1:0]   res_line     [2],
    input  logic [LINE_BITS-1:0]   res_column   [2],
    input  logic                   res_last     [2],
    output logic                   room,
    sct_tok_if.source              tokens
);
    import sct_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    kind_t                  kind_mem   [DEPTH];
    logic [OFFSET_BITS-1:0] pos_mem    [DEPTH];
    logic [LENGTH_BITS-1:0] len_mem    [DEPTH];
    logic [LINE_BITS-1:0]   line_mem   [DEPTH];
    logic [LINE_BITS-1:0]   col_mem    [DEPTH];
    logic                   last_mem   [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS-1:0] wr_ptr_alt;
    logic                pop;

    // room for two tokens
    assign room       = count_reg <= (PTR_BITS + 1)'(DEPTH - 2);
    assign pop        = tokens.valid && tokens.ready;
    assign wr_ptr_alt = wr_ptr_reg + PTR_BITS'(1);

    assign tokens.valid         = count_reg != '0;
    assign tokens.kind          = kind_mem[rd_ptr_reg];
    assign tokens.byte_position = pos_mem[rd_ptr_reg];
    assign tokens.token_length  = len_mem[rd_ptr_reg];
    assign tokens.line          = line_mem[rd_ptr_reg];
    assign tokens.column        = col_mem[rd_ptr_reg];
    assign tokens.last_of_run   = last_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(wr.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_reg + (PTR_BITS + 1)'(wr.count) - (PTR_BITS + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            kind_mem[wr_ptr_reg] <= res_kind[0];
            pos_mem[wr_ptr_reg]  <= res_position[0];
            len_mem[wr_ptr_reg]  <= res_length[0];
            line_mem[wr_ptr_reg] <= res_line[0];
            col_mem[wr_ptr_reg]  <= res_column[0];
            last_mem[wr_ptr_reg] <= res_last[0];
        end
        if (wr.count == 2'd2)
        begin
            kind_mem[wr_ptr_alt] <= res_kind[1];
            pos_mem[wr_ptr_alt]  <= res_position[1];
            len_mem[wr_ptr_alt]  <= res_length[1];
            line_mem[wr_ptr_alt] <= res_line[1];
            col_mem[wr_ptr_alt]  <= res_column[1];
            last_mem[wr_ptr_alt] <= res_last[1];
        end
    end

endmodule

### rtl/source_char_tokenizer.sv
// Source tokenizer taking one byte per transfer on source and giving tokens on
// tokens. A byte is taken every cycle while the queue has room for two tokens: it
// lands in an input register; the scanner updates its mode and counters from it
// when the byte is consumed and writes the tokens it closes into a four-entry
// output queue, so a byte's first token passes the input register and the queue
// before it can be taken. A byte closes at most two tokens (a pending token and
// the byte's own, or a pending token and eof); tokens leave one per cycle while
// the consumer is ready; one byte per cycle holds if most give at most one token.
module source_char_tokenizer #(
    parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEFAULT,
    parameter int LENGTH_BITS = sct_pkg::LENGTH_BITS_DEFAULT,
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    sct_char_if.sink   source,
    sct_tok_if.source  tokens
);
    import sct_pkg::*;

    sct_wr_t                wr;
    logic                   room;
    kind_t                  res_kind     [2];
    logic [OFFSET_BITS-1:0] res_position [2];
    logic [LENGTH_BITS-1:0] res_length   [2];
    logic [LINE_BITS-1:0]   res_line     [2];
    logic [LINE_BITS-1:0]   res_column   [2];
    logic                   res_last     [2];

    sct_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (source.valid),
        .char_ready    (source.ready),
        .char_code     (source.char_code),
        .end_of_source (source.end_of_source),
        .room          (room),
        .wr            (wr),
        .res_kind      (res_kind),
        .res_position  (res_position),
        .res_length    (res_length),
        .res_line      (res_line),
        .res_column    (res_column),
        .res_last      (res_last)
    );

    sct_queue #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .res_kind     (res_kind),
        .res_position (res_position),
        .res_length   (res_length),
        .res_line     (res_line),
        .res_column   (res_column),
        .res_last     (res_last),
        .room         (room),
        .tokens       (tokens)
    );

endmodule
